/* rtl/ctxrd_pkg.sv */
package ctxrd_pkg;

   localparam int DEF_CAPACITY = 32;
   localparam int DEF_ID_BITS  = 16;

   // request codes
   localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
   localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
   localparam logic [1:0] CMD_REMOVE     = 2'd2;
   localparam logic [1:0] CMD_REPORT     = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] context_id;
   } ctxrd_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] head_id;
      logic [5:0]  length;
      logic        is_empty;
   } ctxrd_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       push_front;
      logic       push_back;
      logic       scan_start;
      logic       scan_next;
      logic       rd_ptr;
      logic       rd_next;
      logic       rd_head;
      logic       shift_wr;
      logic       pop_head;
      logic       drop_tail;
      logic       head_cap;
      logic       rsp_load;
      logic [1:0] rsp_status;
   } ctxrd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] req_cmd;
      logic       id_zero;
      logic       full;
      logic       empty;
      logic       match;
      logic       idx_zero;
      logic       idx_last;
      logic       idx_next_last;
      logic       rsp_free;
   } ctxrd_sts_type;

endpackage

/* rtl/context_ready_deque_core.sv */
// Report, rejected requests and remove on an empty queue go straight to the result; a push writes
// the slot, then reads the head back to refresh it. Remove walks the slot memory one entry at a time:
// a front hit advances the head and refreshes it, a tail hit drops the tail, a hit elsewhere shifts
// each later entry forward to close the gap, and a miss walks every entry and reports not found.
// One request is in flight at a time; the next is taken once its result is in the output register.
// Reset clears the fill count and head pointer at once; slots are not cleared and need no pass.
module context_ready_deque_core
   import ctxrd_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY,
   parameter int ID_BITS  = DEF_ID_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  ctxrd_req_type req_payload,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ctxrd_rsp_type rsp_payload
);

   ctxrd_cmd_type cmd;
   ctxrd_sts_type sts;

   ctxrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ctxrd_dp #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/ctxrd_ctrl.sv */
module ctxrd_ctrl
   import ctxrd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  ctxrd_sts_type sts,
   output ctxrd_cmd_type cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EXEC     = 4'd1;
   localparam logic [3:0] S_SCAN_RD  = 4'd2;
   localparam logic [3:0] S_SCAN_CMP = 4'd3;
   localparam logic [3:0] S_SHIFT_RD = 4'd4;
   localparam logic [3:0] S_SHIFT_WR = 4'd5;
   localparam logic [3:0] S_REF_RD   = 4'd6;
   localparam logic [3:0] S_REF_CAP  = 4'd7;
   localparam logic [3:0] S_RESP     = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] status_ff, status_in;

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.rsp_status = status_ff;
      req_stall      = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            case (sts.req_cmd)
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  if (sts.id_zero) begin
                     status_in = ST_INVALID;
                     state_in  = S_RESP;
                  end else if (sts.full) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else begin
                     cmd.push_front = (sts.req_cmd == CMD_PUSH_FRONT);
                     cmd.push_back  = (sts.req_cmd == CMD_PUSH_BACK);
                     status_in      = ST_OK;
                     state_in       = S_REF_RD;
                  end
               end
               CMD_REMOVE: begin
                  if (sts.id_zero) begin
                     status_in = ST_INVALID;
                     state_in  = S_RESP;
                  end else if (sts.empty) begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_RESP;
                  end else begin
                     cmd.scan_start = 1'b1;
                     status_in      = ST_OK;
                     state_in       = S_SCAN_RD;
                  end
               end
               default: begin
                  status_in = ST_OK;
                  state_in  = S_RESP;
               end
            endcase
         end
         S_SCAN_RD: begin
            cmd.rd_ptr = 1'b1;
            state_in   = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (sts.match) begin
               if (sts.idx_zero) begin
                  // front hit: advance the head, then refresh its value
                  cmd.pop_head = 1'b1;
                  state_in     = S_REF_RD;
               end else if (sts.idx_last) begin
                  cmd.drop_tail = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end else if (sts.idx_last) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESP;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            cmd.rd_next = 1'b1;
            state_in    = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            if (sts.idx_next_last) begin
               cmd.drop_tail = 1'b1;
               state_in      = S_RESP;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_REF_RD: begin
            cmd.rd_head = 1'b1;
            state_in    = S_REF_CAP;
         end
         S_REF_CAP: begin
            cmd.head_cap = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            // hold until the output register frees up
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

/* rtl/ctxrd_dp.sv */
module ctxrd_dp
   import ctxrd_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY,
   parameter int ID_BITS  = DEF_ID_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  ctxrd_req_type req_payload,
   input  ctxrd_cmd_type cmd,
   output ctxrd_sts_type sts,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ctxrd_rsp_type rsp_payload
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
   localparam logic [SUM_W-1:0] SUM_CAP  = SUM_W'(CAPACITY);

   logic [ID_BITS-1:0] slots_mem [CAPACITY];

   logic [1:0]         cmd_ff, cmd_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [PTR_W-1:0]   idx_ff, idx_in;
   logic [ID_BITS-1:0] head_val_ff, head_val_in;
   logic [ID_BITS-1:0] rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   ctxrd_rsp_type      rsp_ff, rsp_in;

   logic [PTR_W-1:0]   head_dec, head_nxt, ptr_nxt, tail;
   logic [SUM_W-1:0]   tail_sum;
   logic               wr_en, rd_en;
   logic [PTR_W-1:0]   wr_addr, rd_addr;
   logic [ID_BITS-1:0] wr_data;

   assign head_dec = (head_ff == '0) ? PTR_LAST : head_ff - 1'b1;
   assign head_nxt = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign ptr_nxt  = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail     = (tail_sum >= SUM_CAP) ? PTR_W'(tail_sum - SUM_CAP) : PTR_W'(tail_sum);

   // memory port steering
   always_comb begin
      wr_en   = cmd.push_front | cmd.push_back | cmd.shift_wr;
      wr_addr = ptr_ff;
      wr_data = rd_data_ff;
      if (cmd.push_front) begin
         wr_addr = head_dec;
         wr_data = id_ff;
      end else if (cmd.push_back) begin
         wr_addr = tail;
         wr_data = id_ff;
      end
      rd_en   = cmd.rd_ptr | cmd.rd_next | cmd.rd_head;
      rd_addr = ptr_ff;
      if (cmd.rd_next) begin
         rd_addr = ptr_nxt;
      end else if (cmd.rd_head) begin
         rd_addr = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slots_mem[rd_addr];
      end
   end

   always_comb begin
      cmd_in      = cmd_ff;
      id_in       = id_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      idx_in      = idx_ff;
      head_val_in = head_val_ff;
      if (cmd.capture) begin
         cmd_in = req_payload.cmd;
         id_in  = ID_BITS'(req_payload.context_id);
      end
      if (cmd.push_front) begin
         head_in  = head_dec;
         count_in = count_ff + 1'b1;
      end
      if (cmd.push_back) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.pop_head) begin
         head_in  = head_nxt;
         count_in = count_ff - 1'b1;
      end
      if (cmd.drop_tail) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.scan_start) begin
         ptr_in = head_ff;
         idx_in = '0;
      end
      if (cmd.scan_next | cmd.shift_wr) begin
         ptr_in = ptr_nxt;
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.head_cap) begin
         head_val_in = rd_data_ff;
      end
   end

   always_comb begin
      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);
      rsp_in       = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.status   = cmd.rsp_status;
         rsp_in.head_id  = (count_ff == '0) ? 16'd0 : 16'(head_val_ff);
         rsp_in.length   = 6'(count_ff);
         rsp_in.is_empty = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      head_val_ff <= head_val_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      sts.req_cmd       = cmd_ff;
      sts.id_zero       = (id_ff == '0);
      sts.full          = (count_ff == CNT_FULL);
      sts.empty         = (count_ff == '0);
      sts.match         = (rd_data_ff == id_ff);
      sts.idx_zero      = (idx_ff == '0);
      sts.idx_last      = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
      sts.idx_next_last = ((SUM_W'(idx_ff) + SUM_W'(2)) == SUM_W'(count_ff));
      sts.rsp_free      = ~rsp_valid_ff | ~rsp_stall;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/ctxrd_checker.sv */
module ctxrd_checker
   import ctxrd_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input ctxrd_req_type req_payload,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input ctxrd_rsp_type rsp_payload
);

   localparam logic [5:0] LEN_FULL = 6'(CAPACITY);

   logic req_beat;
   assign req_beat = req_valid & ~req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.is_empty == (rsp_payload.length == 6'd0)))
      else $error("empty flag disagrees with length");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_empty |-> rsp_payload.head_id == 16'd0)
      else $error("empty queue shows a head identifier");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_FULL) |-> rsp_payload.length == LEN_FULL)
      else $error("full status with a queue that is not full");

   // a request is held off for at least the cycle after its beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_payload.cmd == CMD_REPORT || req_payload.cmd != CMD_REPORT)
      |=> req_stall)
      else $error("second request taken while one is in flight");

endmodule

bind context_ready_deque_core ctxrd_checker #(
   .CAPACITY (CAPACITY)
) u_ctxrd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
